[hw/rtl/pte_pkg.sv]
// Shared widths, register indexes and payload types of the track endpoint finder.
// Used by the core and by its port checker; depends on nothing.
`default_nettype none
package pte_pkg;
  localparam int COORD_W    = 16;
  localparam int LEN_W      = 13;
  localparam int DIM_W      = 7;
  localparam int ORG_W      = 15;
  localparam int CFG_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_XORG   = 2'd2;
  localparam logic [1:0] REG_YORG   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LEN_W-1:0]          len_t;
endpackage
`default_nettype wire

[hw/rtl/pte_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module pte_ram #(
  parameter int W = 1,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/pixel_track_endpoint_finder_core.sv]
// Track endpoint finder: frame load, seed split and up to two breadth-first walks (pte_pkg, pte_ram).
// Pixels load one per cycle with busy low. After the last pixel an empty frame strobes its
// result from the evaluate state, a lone pixel at the end of the seed split (one bit a cycle).
// A walk fetches each queued pixel, probes its in-frame neighbors one by one, closes each level
// and then clears every queued pixel's mark; one frame at a time, and the receiver cannot stall the result.
// Synchronous active-low reset; busy then stays high while the marks of all MAX_WIDTH*MAX_HEIGHT cells clear.
`default_nettype none
module pixel_track_endpoint_finder_core #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int CHARGE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [CHARGE_BITS-1:0]    in_pixel_charge,
  input  wire logic                             in_last_pixel,
  output logic                                  out_valid,
  output pte_pkg::coord_t                       out_start_x,
  output pte_pkg::coord_t                       out_start_y,
  output pte_pkg::coord_t                       out_end_x,
  output pte_pkg::coord_t                       out_end_y,
  output pte_pkg::len_t                         out_track_len,
  output logic                                  out_empty_frame,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pte_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [pte_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pte_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import pte_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int PB    = $clog2(CELLS);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int QW    = RB + CB;
  localparam int DCW   = $clog2(PB);

  localparam logic [3:0] S_CLRALL = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_WINIT  = 4'd4;
  localparam logic [3:0] S_DEQ    = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_NB     = 4'd7;
  localparam logic [3:0] S_NBCHK  = 4'd8;
  localparam logic [3:0] S_CLR    = 4'd9;
  localparam logic [3:0] S_CLRW   = 4'd10;

  localparam logic [CHARGE_BITS-1:0] SIGN_KEY = {1'b1, {(CHARGE_BITS-1){1'b0}}};

  function automatic coord_t mk_coord(logic [COORD_W-1:0] idx, logic [ORG_W-1:0] org,
                                      logic one);
    logic [COORD_W-1:0] org_x;
    org_x = {{(COORD_W-ORG_W){org[ORG_W-1]}}, org};
    return coord_t'(idx + org_x + COORD_W'(one));
  endfunction

  // registers
  logic [3:0]             state_r, state_nxt;
  logic [DIM_W-1:0]       width_r, height_r;
  logic [ORG_W-1:0]       xorg_r, yorg_r;
  logic [PB:0]            pos_r, pos_nxt;
  logic [CHARGE_BITS-1:0] bkey_r, bkey_nxt;
  logic [PB-1:0]          bpos_r, bpos_nxt;
  logic [1:0]             occn_r, occn_nxt;
  logic [PB-1:0]          sec_r, sec_nxt;
  logic [DCW-1:0]         dcnt_r, dcnt_nxt;
  logic [PB-1:0]          dq_r, dq_nxt;
  logic [WB:0]            drem_r, drem_nxt;
  logic [QW-1:0]          seed_r, seed_nxt;
  logic [QW-1:0]          src_r, src_nxt;
  logic [QW-1:0]          far_r, far_nxt;
  logic [QW-1:0]          cur_r, cur_nxt;
  logic [QW-1:0]          cmin_r, cmin_nxt;
  logic [PB:0]            head_r, head_nxt;
  logic [PB:0]            qend_r, qend_nxt;
  logic [PB:0]            tail_r, tail_nxt;
  logic [LEN_W-1:0]       lvl_r, lvl_nxt;
  logic [1:0]             nbk_r, nbk_nxt;
  logic [QW-1:0]          nbrc_r, nbrc_nxt;
  logic [PB-1:0]          nbadr_r, nbadr_nxt;
  logic                   walk2_r, walk2_nxt;
  logic [PB:0]            clr_r, clr_nxt;
  logic                   ov_r, ov_nxt;
  coord_t                 osx_r, osx_nxt, osy_r, osy_nxt, oex_r, oex_nxt, oey_r, oey_nxt;
  len_t                   olen_r, olen_nxt;
  logic                   oemp_r, oemp_nxt;

  // frame geometry, clamped
  logic [WB-1:0] w_c;
  logic [HB-1:0] h_c;
  logic [PB:0]   n_c;

  always_comb begin
    if (width_r == '0) w_c = WB'(1);
    else if (int'(width_r) > MAX_WIDTH) w_c = WB'(MAX_WIDTH);
    else w_c = WB'(width_r);
    if (height_r == '0) h_c = HB'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_c = HB'(MAX_HEIGHT);
    else h_c = HB'(height_r);
  end
  assign n_c = (PB+1)'(w_c) * (PB+1)'(h_c);

  // memories
  logic          occ_we, occ_wd, occ_rd;
  logic          vis_we, vis_wd, vis_rd;
  logic [PB-1:0] occ_wa, vis_wa, map_ra;
  logic          q_we;
  logic [PB-1:0] q_wa, q_ra;
  logic [QW-1:0] q_wd, q_rd;

  pte_ram #(.W(1), .D(CELLS)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(map_ra), .rdata(occ_rd)
  );
  pte_ram #(.W(1), .D(CELLS)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(map_ra), .rdata(vis_rd)
  );
  pte_ram #(.W(QW), .D(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  // shared row * width + column address unit
  logic [RB-1:0] m_row;
  logic [CB-1:0] m_col;
  logic [PB:0]   m_prod;
  logic [PB-1:0] m_addr;
  assign m_prod = (PB+1)'(m_row) * (PB+1)'(w_c) + (PB+1)'(m_col);
  assign m_addr = m_prod[PB-1:0];

  // load-side item decode
  logic                   accept;
  logic [CHARGE_BITS-1:0] key_c;
  logic                   positive;
  assign accept   = start && (state_r == S_IDLE);
  assign key_c    = in_pixel_charge ^ SIGN_KEY;
  assign positive = !in_pixel_charge[CHARGE_BITS-1] && (in_pixel_charge != '0);

  // neighbor candidate of the dequeued pixel
  logic [RB-1:0] cr, nr;
  logic [CB-1:0] cc, nc;
  logic          nb_ok;
  assign cr = cur_r[QW-1:CB];
  assign cc = cur_r[CB-1:0];
  always_comb begin
    nr    = cr;
    nc    = cc;
    nb_ok = 1'b0;
    case (nbk_r)
      2'd0: begin
        nb_ok = ((CB+1)'(cc) + (CB+1)'(1)) < (CB+1)'(w_c);
        nc    = cc + CB'(1);
      end
      2'd1: begin
        nb_ok = cc != '0;
        nc    = cc - CB'(1);
      end
      2'd2: begin
        nb_ok = cr != '0;
        nr    = cr - RB'(1);
      end
      default: begin
        nb_ok = ((RB+1)'(cr) + (RB+1)'(1)) < (RB+1)'(h_c);
        nr    = cr + RB'(1);
      end
    endcase
  end

  // divider step
  logic [WB:0] d_sh;
  logic        d_bit;
  logic [WB:0] d_rem;
  assign d_sh  = {drem_r[WB-1:0], dq_r[PB-1]};
  assign d_bit = d_sh >= (WB+1)'(w_c);
  assign d_rem = d_bit ? d_sh - (WB+1)'(w_c) : d_sh;

  // control and datapath next state
  always_comb begin
    logic emit;
    emit      = 1'b0;
    state_nxt = state_r;
    pos_nxt   = pos_r;   bkey_nxt = bkey_r;  bpos_nxt = bpos_r;
    occn_nxt  = occn_r;  sec_nxt  = sec_r;
    dcnt_nxt  = dcnt_r;  dq_nxt   = dq_r;    drem_nxt = drem_r;
    seed_nxt  = seed_r;  src_nxt  = src_r;   far_nxt  = far_r;
    cur_nxt   = cur_r;   cmin_nxt = cmin_r;
    head_nxt  = head_r;  qend_nxt = qend_r;  tail_nxt = tail_r;
    lvl_nxt   = lvl_r;   nbk_nxt  = nbk_r;   nbrc_nxt = nbrc_r;
    nbadr_nxt = nbadr_r; walk2_nxt = walk2_r; clr_nxt = clr_r;
    ov_nxt    = 1'b0;
    osx_nxt = osx_r; osy_nxt = osy_r; oex_nxt = oex_r; oey_nxt = oey_r;
    olen_nxt = olen_r; oemp_nxt = oemp_r;
    occ_we = 1'b0; occ_wa = pos_r[PB-1:0]; occ_wd = positive;
    vis_we = 1'b0; vis_wa = clr_r[PB-1:0]; vis_wd = 1'b0;
    q_we   = 1'b0; q_wa   = tail_r[PB-1:0]; q_wd = nbrc_r;
    q_ra   = clr_r[PB-1:0];
    m_row  = src_r[QW-1:CB];
    m_col  = src_r[CB-1:0];
    map_ra = m_addr;

    case (state_r)
      // sweep the visited memory clear after reset
      S_CLRALL: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (PB+1)'(CELLS-1)) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      // load one pixel per item
      S_IDLE: begin
        if (accept) begin
          if (pos_r < n_c) begin
            occ_we  = 1'b1;
            pos_nxt = pos_r + 1'b1;
            if (key_c > bkey_r) begin
              bkey_nxt = key_c;
              bpos_nxt = pos_r[PB-1:0];
            end
            if (positive) begin
              if (occn_r == 2'd1) sec_nxt = pos_r[PB-1:0];
              if (occn_r != 2'd2) occn_nxt = occn_r + 2'd1;
            end
          end
          if (in_last_pixel) state_nxt = S_EVAL;
        end
      end
      // seed must be occupied and inside the frame
      S_EVAL: begin
        if (bkey_r > SIGN_KEY && (PB+1)'(bpos_r) < n_c) begin
          dq_nxt    = bpos_r;
          drem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          emit     = 1'b1;
          osx_nxt  = '0; osy_nxt = '0; oex_nxt = '0; oey_nxt = '0;
          olen_nxt = '0;
          oemp_nxt = 1'b1;
        end
      end
      // split seed position into row and column, one bit per cycle
      S_DIV: begin
        dq_nxt   = {dq_r[PB-2:0], d_bit};
        drem_nxt = d_rem;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(PB-1)) begin
          seed_nxt = {dq_nxt[RB-1:0], d_rem[CB-1:0]};
          if (occn_r == 2'd2 && (PB+1)'(sec_r) < n_c) begin
            src_nxt   = seed_nxt;
            walk2_nxt = 1'b0;
            state_nxt = S_WINIT;
          end else begin
            emit     = 1'b1;
            osx_nxt  = mk_coord(COORD_W'(d_rem[CB-1:0]), xorg_r, 1'b1);
            osy_nxt  = mk_coord(COORD_W'(dq_nxt[RB-1:0]), yorg_r, 1'b1);
            oex_nxt  = mk_coord(COORD_W'(d_rem[CB-1:0]), xorg_r, 1'b0);
            oey_nxt  = mk_coord(COORD_W'(dq_nxt[RB-1:0]), yorg_r, 1'b0);
            olen_nxt = len_t'(1);
            oemp_nxt = 1'b0;
          end
        end
      end
      // mark and enqueue the walk origin
      S_WINIT: begin
        vis_we    = 1'b1;
        vis_wa    = m_addr;
        vis_wd    = 1'b1;
        q_we      = 1'b1;
        q_wa      = '0;
        q_wd      = src_r;
        head_nxt  = '0;
        qend_nxt  = (PB+1)'(1);
        tail_nxt  = (PB+1)'(1);
        lvl_nxt   = '0;
        cmin_nxt  = '1;
        state_nxt = S_DEQ;
      end
      // close a level or fetch the next queued pixel
      S_DEQ: begin
        q_ra = head_r[PB-1:0];
        if (head_r == qend_r) begin
          if (tail_r == qend_r) begin
            far_nxt   = cmin_r;
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else begin
            qend_nxt = tail_r;
            lvl_nxt  = lvl_r + 1'b1;
            cmin_nxt = '1;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cur_nxt   = q_rd;
        if (q_rd < cmin_r) cmin_nxt = q_rd;
        nbk_nxt   = '0;
        state_nxt = S_NB;
      end
      // probe one neighbor: issue map reads
      S_NB: begin
        m_row = nr;
        m_col = nc;
        if (nb_ok) begin
          nbrc_nxt  = {nr, nc};
          nbadr_nxt = m_addr;
          state_nxt = S_NBCHK;
        end else if (nbk_r == 2'd3) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_DEQ;
        end else begin
          nbk_nxt = nbk_r + 2'd1;
        end
      end
      // enqueue an occupied, unvisited neighbor
      S_NBCHK: begin
        if (occ_rd && !vis_rd && (PB+1)'(nbadr_r) < pos_r) begin
          vis_we   = 1'b1;
          vis_wa   = nbadr_r;
          vis_wd   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        if (nbk_r == 2'd3) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_DEQ;
        end else begin
          nbk_nxt   = nbk_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      // drop visited marks of every queued pixel, then advance
      S_CLR: begin
        if (clr_r == tail_r) begin
          if (walk2_r) begin
            emit     = 1'b1;
            osx_nxt  = mk_coord(COORD_W'(src_r[CB-1:0]), xorg_r, 1'b0);
            osy_nxt  = mk_coord(COORD_W'(src_r[QW-1:CB]), yorg_r, 1'b0);
            oex_nxt  = mk_coord(COORD_W'(far_r[CB-1:0]), xorg_r, 1'b0);
            oey_nxt  = mk_coord(COORD_W'(far_r[QW-1:CB]), yorg_r, 1'b0);
            olen_nxt = len_t'(lvl_r + 1'b1);
            oemp_nxt = 1'b0;
          end else if (lvl_r == '0) begin
            emit     = 1'b1;
            osx_nxt  = mk_coord(COORD_W'(seed_r[CB-1:0]), xorg_r, 1'b0);
            osy_nxt  = mk_coord(COORD_W'(seed_r[QW-1:CB]), yorg_r, 1'b0);
            oex_nxt  = osx_nxt;
            oey_nxt  = osy_nxt;
            olen_nxt = len_t'(1);
            oemp_nxt = 1'b0;
          end else begin
            src_nxt   = far_r;
            walk2_nxt = 1'b1;
            state_nxt = S_WINIT;
          end
        end else begin
          state_nxt = S_CLRW;
        end
      end
      S_CLRW: begin
        m_row     = q_rd[QW-1:CB];
        m_col     = q_rd[CB-1:0];
        vis_we    = 1'b1;
        vis_wa    = m_addr;
        vis_wd    = 1'b0;
        clr_nxt   = clr_r + 1'b1;
        state_nxt = S_CLR;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // deliver the result and clear the frame state
    if (emit) begin
      ov_nxt    = 1'b1;
      state_nxt = S_IDLE;
      pos_nxt   = '0;
      bkey_nxt  = '0;
      bpos_nxt  = '0;
      occn_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLRALL;
      clr_r   <= '0;
      pos_r   <= '0;
      bkey_r  <= '0;
      bpos_r  <= '0;
      occn_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pos_r   <= pos_nxt;
      bkey_r  <= bkey_nxt;
      bpos_r  <= bpos_nxt;
      occn_r  <= occn_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;   dcnt_r <= dcnt_nxt; dq_r   <= dq_nxt;   drem_r <= drem_nxt;
    seed_r  <= seed_nxt;  src_r  <= src_nxt;  far_r  <= far_nxt;  cur_r  <= cur_nxt;
    cmin_r  <= cmin_nxt;  head_r <= head_nxt; qend_r <= qend_nxt; tail_r <= tail_nxt;
    lvl_r   <= lvl_nxt;   nbk_r  <= nbk_nxt;  nbrc_r <= nbrc_nxt; nbadr_r <= nbadr_nxt;
    walk2_r <= walk2_nxt;
    osx_r   <= osx_nxt;   osy_r  <= osy_nxt;  oex_r  <= oex_nxt;  oey_r  <= oey_nxt;
    olen_r  <= olen_nxt;  oemp_r <= oemp_nxt;
  end

  // configuration registers
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      xorg_r   <= ORG_W'(1);
      yorg_r   <= ORG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_XORG:   xorg_r   <= pwdata[ORG_W-1:0];
        REG_YORG:   yorg_r   <= pwdata[ORG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DATA_W'(width_r);
      REG_HEIGHT: prdata = APB_DATA_W'(height_r);
      REG_XORG:   prdata = APB_DATA_W'(xorg_r);
      REG_YORG:   prdata = APB_DATA_W'(yorg_r);
      default:    prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_start_x      = osx_r;
  assign out_start_y      = osy_r;
  assign out_end_x        = oex_r;
  assign out_end_y        = oey_r;
  assign out_track_len    = olen_r;
  assign out_empty_frame  = oemp_r;
endmodule
`default_nettype wire

[hw/rtl/pte_checker.sv]
// Port-level checks for the track endpoint finder, bound to its top level.
// Uses pte_pkg for payload types.
`default_nettype none
module pte_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            in_last_pixel,
  input wire logic            out_valid,
  input wire pte_pkg::coord_t out_start_x,
  input wire pte_pkg::coord_t out_start_y,
  input wire pte_pkg::coord_t out_end_x,
  input wire pte_pkg::coord_t out_end_y,
  input wire pte_pkg::len_t   out_track_len,
  input wire logic            out_empty_frame
);
  import pte_pkg::*;

  // a result only follows a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without preceding work");

  // empty frame carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |-> out_start_x == '0 && out_start_y == '0 &&
      out_end_x == '0 && out_end_y == '0 && out_track_len == '0)
    else $error("empty frame with nonzero fields");

  // a found track is at least one pixel long
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_frame |-> out_track_len != '0)
    else $error("track of zero length");

  // mid-frame pixels never stall the loader
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_pixel |=> !busy) else $error("busy after mid-frame item");

  // no results on back-to-back cycles
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");
endmodule

bind pixel_track_endpoint_finder_core pte_checker u_pte_checker (.*);
`default_nettype wire

[tb/sv/tb_pixel_track_endpoint_finder_core.sv]
// Testbench for the pixel track endpoint finder core: frames of signed charges in,
// one endpoint result per frame out, checked against a built-in frame predictor.
// Depends on pte_pkg and pixel_track_endpoint_finder_core.
`timescale 1ns / 100ps
module tb_pixel_track_endpoint_finder_core;
  import pte_pkg::*;

  localparam int MAXW = 64;
  localparam int MAXH = 64;
  localparam int CELLS = MAXW * MAXH;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [12:0] len;
    logic        empty;
  } track_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_pixel_charge = '0;
  logic in_last_pixel = 1'b0;
  logic out_valid;
  coord_t out_start_x, out_start_y, out_end_x, out_end_y;
  len_t out_track_len;
  logic out_empty_frame;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  pixel_track_endpoint_finder_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_charge(in_pixel_charge), .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_start_x(out_start_x), .out_start_y(out_start_y),
    .out_end_x(out_end_x), .out_end_y(out_end_y), .out_track_len(out_track_len),
    .out_empty_frame(out_empty_frame), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  bit          occ[CELLS];
  bit          seen[CELLS];
  int          bfs_q[CELLS];
  int          load_pos;
  logic [15:0] bright_key;
  int          bright_pos;
  int          far_pos;
  int          far_level;
  logic [6:0]  cur_w = 7'd64, cur_h = 7'd64;
  logic [14:0] cur_xo = 15'd1, cur_yo = 15'd1;

  track_res_t  pending_tracks[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          frames_sent = 0;
  int          pixels_sent = 0;

  function automatic int clamp_dim(logic [6:0] v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic void clear_frame();
    foreach (occ[i]) occ[i] = 1'b0;
    load_pos = 0;
    bright_key = '0;
    bright_pos = 0;
  endfunction

  // Breadth-first walk; leaves far_pos and far_level
  function automatic void bfs_walk(int seed, int w, int h);
    int head, tail, fill, lvl, best, p, c, r, q, k;
    int nb[4];
    int nn;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[seed] = 1'b1;
    bfs_q[0] = seed;
    head = 0; tail = 1; lvl = 0;
    forever begin
      best = bfs_q[head];
      fill = tail;
      for (int i = head; i < tail; i++) begin
        p = bfs_q[i];
        c = p % w; r = p / w;
        nn = 0;
        if (p < best) best = p;
        if (c + 1 < w) begin nb[nn] = p + 1; nn++; end
        if (c > 0) begin nb[nn] = p - 1; nn++; end
        if (r > 0) begin nb[nn] = p - w; nn++; end
        if (r + 1 < h) begin nb[nn] = p + w; nn++; end
        for (k = 0; k < nn; k++) begin
          q = nb[k];
          if (occ[q] && !seen[q] && fill < CELLS) begin
            seen[q] = 1'b1;
            bfs_q[fill] = q;
            fill++;
          end
        end
      end
      far_pos = best;
      far_level = lvl;
      if (fill == tail) break;
      head = tail;
      tail = fill;
      lvl++;
    end
  endfunction

  // Fold one pixel into the frame; on the last pixel, queue the expected track
  function automatic void predict_track(logic [15:0] charge, logic last);
    int w, h, n, cnt, seed, ec, er, sc, sr;
    logic [15:0] key, xo, yo;
    bit positive;
    track_res_t t;
    w = clamp_dim(cur_w, MAXW);
    h = clamp_dim(cur_h, MAXH);
    n = w * h;
    key = charge ^ 16'h8000;
    positive = !charge[15] && charge != 0;
    if (load_pos < n) begin
      occ[load_pos] = positive;
      if (key > bright_key) begin
        bright_key = key;
        bright_pos = load_pos;
      end
      load_pos++;
    end
    if (!last) return;
    cnt = 0;
    for (int i = 0; i < n; i++) cnt += occ[i];
    seed = bright_pos;
    xo = {cur_xo[14], cur_xo};
    yo = {cur_yo[14], cur_yo};
    t = '0;
    if (cnt == 0 || seed >= n || !occ[seed]) begin
      t.empty = 1'b1;
    end else begin
      ec = seed % w; er = seed / w;
      if (cnt == 1) begin
        t.sx = 16'(ec + xo + 1); t.sy = 16'(er + yo + 1);
        t.ex = 16'(ec + xo);     t.ey = 16'(er + yo);
        t.len = 13'(1);
      end else begin
        bfs_walk(seed, w, h);
        if (far_level == 0) begin
          t.sx = 16'(ec + xo); t.ex = 16'(ec + xo);
          t.sy = 16'(er + yo); t.ey = 16'(er + yo);
          t.len = 13'(1);
        end else begin
          sc = far_pos % w; sr = far_pos / w;
          bfs_walk(far_pos, w, h);
          t.sx = 16'(sc + xo); t.sy = 16'(sr + yo);
          t.ex = 16'((far_pos % w) + xo); t.ey = 16'((far_pos / w) + yo);
          t.len = 13'(far_level + 1);
        end
      end
    end
    pending_tracks = {pending_tracks, t};
    clear_frame();
  endfunction

  // Check each strobed result against the oldest expected track
  always @(posedge clk) begin
    track_res_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_start_x, out_start_y, out_end_x, out_end_y, out_track_len,
              out_empty_frame};
      results_seen++;
      if (pending_tracks.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        fail_count++;
      end else begin
        want = pending_tracks.pop_front();
        if (got.sx !== want.sx) begin
          $display("%0t: start_x expected %0d actual %0d", $time,
                   $signed(want.sx), $signed(got.sx));
          fail_count++;
        end
        if (got.sy !== want.sy) begin
          $display("%0t: start_y expected %0d actual %0d", $time,
                   $signed(want.sy), $signed(got.sy));
          fail_count++;
        end
        if (got.ex !== want.ex) begin
          $display("%0t: end_x expected %0d actual %0d", $time,
                   $signed(want.ex), $signed(got.ex));
          fail_count++;
        end
        if (got.ey !== want.ey) begin
          $display("%0t: end_y expected %0d actual %0d", $time,
                   $signed(want.ey), $signed(got.ey));
          fail_count++;
        end
        if (got.len !== want.len) begin
          $display("%0t: track length expected %0d actual %0d", $time, want.len, got.len);
          fail_count++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: empty_frame expected %0d actual %0d", $time,
                   want.empty, got.empty);
          fail_count++;
        end
      end
    end
  end

  // Sender burst state
  int burst_left = 0;

  // Send one pixel item; random gaps between bursts
  task automatic send_pixel(logic [15:0] charge, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_pixel_charge <= charge;
    in_last_pixel <= last;
    // wait for a cycle with busy low; the edge that ends it takes the item
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_track(charge, last);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Hold until every expected track has come out, plus the walk tail
  task automatic drain_tracks();
    start <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    start <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WIDTH:  cur_w = value[6:0];
      REG_HEIGHT: cur_h = value[6:0];
      REG_XORG:   cur_xo = value[14:0];
      default:    cur_yo = value[14:0];
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int xo, int yo);
    drain_tracks();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_XORG, xo);
    write_reg(REG_YORG, yo);
  endtask

  // Random charge mostly negative/zero background
  function automatic logic [15:0] noise_charge();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h0000;
      2: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    set_frame(3, 3, 16'h7FFF & -5, 16383);
    // all empty frame
    for (int i = 0; i < 9; i++) send_pixel(16'h8000, i == 8);
    // lone pixel
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 16'h7FFF : 16'h0000, i == 8);
    // isolated seed with another pixel in the opposite corner
    for (int i = 0; i < 9; i++) send_pixel(i == 0 ? 16'd9 : (i == 8 ? 16'd1 : 16'hFFFF), i == 8);
    drain_tracks();
    // short frame, plus too many pixels in a 1x1 frame with extreme origins
    set_frame(0, 0, 16'h4000, 16'h4000);
    send_pixel(16'd5, 1'b0);
    send_pixel(16'd7, 1'b1);
    set_frame(100, 2, 0, 0);
    send_pixel(16'd1, 1'b0);
    send_pixel(16'd2, 1'b1);
    // dimensions changed mid-frame drop the seed
    set_frame(4, 4, 0, 0);
    for (int i = 0; i < 10; i++) send_pixel(i == 9 ? 16'd100 : 16'd3, 1'b0);
    write_reg(REG_HEIGHT, 2);
    send_pixel(16'd1, 1'b1);
  endtask

  // Random frames: noise or random positive and negative charges; small frames dominate
  task automatic test_random_frames();
    int w, h, n, kind, pos, np;
    while (pixels_sent < 1400) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w = $urandom_range(32, 64); h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 8); h = $urandom_range(1, 8);
      end
      set_frame(w, h, $urandom_range(0, 16'h7FFF), $urandom_range(0, 16'h7FFF));
      n = w * h;
      np = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n + 3) : n;
      repeat ($urandom_range(1, 4)) begin
        if (pixels_sent >= 1400) break;
        pos = $urandom_range(0, n - 1);
        for (int i = 0; i < np; i++) begin
          if (kind < 3) send_pixel(noise_charge(), i == np - 1);
          else send_pixel(($urandom_range(0, 2) != 0) ? 16'($urandom_range(1, 32767))
                          : 16'($urandom_range(0, 32768) | 16'h8000), i == np - 1);
        end
        if (pos == 0) drain_tracks();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    clear_frame();
    @(posedge clk);
    test_directed();
    test_random_frames();
    drain_tracks();
    $display("Covered %0d pixels in %0d frames, %0d results checked.",
             pixels_sent, frames_sent, results_seen);
    if (fail_count == 0) begin
      $display("PASS pixel_track_endpoint_finder_core");
    end else begin
      $display("FAIL pixel_track_endpoint_finder_core");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL pixel_track_endpoint_finder_core");
    $finish;
  end
endmodule
